// ===== rtl/assert_macros.svh =====
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Overlapping implication, disabled during reset.
`define LFU_ASSERT_IMP(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define LFU_ASSERT_NXT(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");

`endif

// ===== rtl/lfu_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package lfu_pkg;
  localparam int unsigned DEPTH  = 64;
  localparam int unsigned IDX_W  = $clog2(DEPTH);
  localparam int unsigned OCC_W  = 7;
  localparam int unsigned KEY_W  = 32;
  localparam int unsigned VAL_W  = 32;
  localparam int unsigned TIME_W = 32;
  localparam int unsigned DEC_W  = 16;
  localparam int unsigned DCNT_W = 6;

  localparam logic [2:0] OP_LOOKUP = 3'd0;
  localparam logic [2:0] OP_PEEK   = 3'd1;
  localparam logic [2:0] OP_WRITE  = 3'd2;
  localparam logic [2:0] OP_REMOVE = 3'd3;
  localparam logic [2:0] OP_EVICT  = 3'd4;

  localparam logic [1:0] ST_DONE   = 2'd0;
  localparam logic [1:0] ST_ABSENT = 2'd1;
  localparam logic [1:0] ST_EMPTY  = 2'd2;

  localparam logic [3:0] ADDR_CAP   = 4'h0;
  localparam logic [3:0] ADDR_IVIS  = 4'h4;
  localparam logic [3:0] ADDR_DECAY = 4'h8;

  typedef enum logic [3:0] {
    S_IDLE, S_FD_RD, S_FD_CMP, S_ACT, S_SC_RD, S_SC_CHK,
    S_SC_DIV, S_SC_CMP, S_EVI, S_INS, S_DONE
  } state_t;

  typedef struct packed {
    logic latch;
    logic idx_clr;
    logic idx_inc;
    logic mem_rd;
    logic find_chk;
    logic act;
    logic div_start;
    logic best_upd;
    logic evict;
    logic insert;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic [2:0] op;
    logic       match;
    logic       found;
    logic       idx_last;
    logic       live_cur;
    logic       div_done;
    logic       need_evict;
  } sts_t;

  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [VAL_W-1:0]  value;
    logic [31:0]       visits;
    logic [TIME_W-1:0] last;
  } entry_t;
endpackage
`default_nettype wire

// ===== rtl/lfu_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
module lfu_ctrl (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         start,
  input  wire logic [2:0]   in_operation,
  input  wire lfu_pkg::sts_t sts,
  output lfu_pkg::cmd_t     cmd,
  output logic              busy
);
  import lfu_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          if (in_operation == OP_EVICT)     state_nxt = S_SC_RD;
          else if (in_operation > OP_EVICT) state_nxt = S_DONE;
          else                              state_nxt = S_FD_RD;
        end
      end
      S_FD_RD:  state_nxt = S_FD_CMP;
      S_FD_CMP: begin
        if (sts.match || sts.idx_last) state_nxt = S_ACT;
        else                           state_nxt = S_FD_RD;
      end
      S_ACT: begin
        if (sts.op == OP_WRITE && !sts.found)
          state_nxt = sts.need_evict ? S_SC_RD : S_INS;
        else
          state_nxt = S_DONE;
      end
      S_SC_RD:  state_nxt = S_SC_CHK;
      S_SC_CHK: begin
        if (sts.live_cur)      state_nxt = S_SC_DIV;
        else if (sts.idx_last) state_nxt = S_EVI;
        else                   state_nxt = S_SC_RD;
      end
      S_SC_DIV: if (sts.div_done) state_nxt = S_SC_CMP;
      S_SC_CMP: state_nxt = sts.idx_last ? S_EVI : S_SC_RD;
      S_EVI:    state_nxt = (sts.op == OP_WRITE) ? S_INS : S_DONE;
      S_INS:    state_nxt = S_DONE;
      S_DONE:   state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state_r)
      S_IDLE: begin
        cmd.latch   = start;
        cmd.idx_clr = start;
      end
      S_FD_RD:  cmd.mem_rd = 1'b1;
      S_FD_CMP: begin
        cmd.find_chk = 1'b1;
        cmd.idx_inc  = !sts.match && !sts.idx_last;
      end
      S_ACT: begin
        cmd.act     = 1'b1;
        cmd.idx_clr = 1'b1;
      end
      S_SC_RD:  cmd.mem_rd = 1'b1;
      S_SC_CHK: begin
        cmd.div_start = sts.live_cur;
        cmd.idx_inc   = !sts.live_cur && !sts.idx_last;
      end
      S_SC_DIV: ;
      S_SC_CMP: begin
        cmd.best_upd = 1'b1;
        cmd.idx_inc  = !sts.idx_last;
      end
      S_EVI:    cmd.evict  = 1'b1;
      S_INS:    cmd.insert = 1'b1;
      S_DONE:   cmd.emit   = 1'b1;
      default:  ;
    endcase
  end

  assign busy = (state_r != S_IDLE);
endmodule
`default_nettype wire

// ===== rtl/lfu_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
module lfu_dp (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic [2:0]                  in_operation,
  input  wire logic [lfu_pkg::KEY_W-1:0]   in_key,
  input  wire logic [lfu_pkg::VAL_W-1:0]   in_write_value,
  input  wire logic [lfu_pkg::TIME_W-1:0]  in_now_minutes,
  input  wire logic [lfu_pkg::OCC_W-1:0]   cap_eff,
  input  wire logic [31:0]                 init_visits,
  input  wire logic [lfu_pkg::DEC_W-1:0]   decay_eff,
  input  wire lfu_pkg::cmd_t               cmd,
  output lfu_pkg::sts_t                    sts,
  output logic                             out_strobe,
  output logic [1:0]                       out_status,
  output logic [lfu_pkg::VAL_W-1:0]        out_read_value,
  output logic                             out_evicted,
  output logic [lfu_pkg::KEY_W-1:0]        out_evicted_key,
  output logic [lfu_pkg::OCC_W-1:0]        out_occupancy,
  output logic [31:0]                      out_hit_total,
  output logic [31:0]                      out_miss_total
);
  import lfu_pkg::*;

  logic [DEPTH-1:0]  live_r;
  logic [OCC_W-1:0]  occ_r;
  logic [31:0]       hit_r, miss_r;
  logic [2:0]        op_r;
  logic [KEY_W-1:0]  key_r;
  logic [VAL_W-1:0]  wval_r;
  logic [TIME_W-1:0] now_r;
  logic [IDX_W-1:0]  idx_r;
  logic              found_r;
  entry_t            mem [DEPTH];
  entry_t            rd_r;
  logic              strobe_r;
  logic [1:0]        status_r;
  logic [VAL_W-1:0]  rval_r;
  logic              ev_r;
  logic [KEY_W-1:0]  evkey_r;
  logic              best_v_r;
  logic [31:0]       best_w_r;
  logic [KEY_W-1:0]  best_key_r;
  logic [IDX_W-1:0]  best_idx_r;
  logic [DEC_W:0]    rem_r;
  logic [TIME_W-1:0] quo_r;
  logic [DCNT_W-1:0] dcnt_r;

  logic              match;
  logic              mem_we;
  logic [IDX_W-1:0]  mem_wa;
  entry_t            mem_wd;
  logic [IDX_W-1:0]  free_idx;
  logic [DEC_W:0]    trial;
  logic [31:0]       weight;

  assign match = live_r[idx_r] && (rd_r.key == key_r);

  // lowest free slot
  always_comb begin
    free_idx = '0;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (!live_r[i]) free_idx = IDX_W'(i);
    end
  end

  always_comb begin
    mem_we = 1'b0;
    mem_wa = idx_r;
    mem_wd = rd_r;
    if (cmd.act && found_r) begin
      if (op_r == OP_LOOKUP) begin
        mem_we = 1'b1;
        if (rd_r.visits != 32'hFFFF_FFFF) mem_wd.visits = rd_r.visits + 32'd1;
        mem_wd.last = now_r;
      end else if (op_r == OP_WRITE) begin
        mem_we = 1'b1;
        mem_wd.value = wval_r;
      end
    end
    if (cmd.insert) begin
      mem_we = 1'b1;
      mem_wa = free_idx;
      mem_wd = '{key: key_r, value: wval_r, visits: init_visits, last: now_r};
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (cmd.mem_rd) rd_r <= mem[idx_r];
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_r   <= in_operation;
      key_r  <= in_key;
      wval_r <= in_write_value;
      now_r  <= in_now_minutes;
    end
    if (cmd.idx_clr)      idx_r <= '0;
    else if (cmd.idx_inc) idx_r <= idx_r + IDX_W'(1);
  end

  // restoring divider: elapsed minutes / decay, one quotient bit per cycle
  assign trial = {rem_r[DEC_W-1:0], quo_r[TIME_W-1]};
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dcnt_r <= '0;
    end else if (cmd.div_start) begin
      rem_r  <= '0;
      quo_r  <= now_r - rd_r.last;
      dcnt_r <= DCNT_W'(TIME_W);
    end else if (dcnt_r != '0) begin
      dcnt_r <= dcnt_r - DCNT_W'(1);
      if (trial >= {1'b0, decay_eff}) begin
        rem_r <= trial - {1'b0, decay_eff};
        quo_r <= {quo_r[TIME_W-2:0], 1'b1};
      end else begin
        rem_r <= trial;
        quo_r <= {quo_r[TIME_W-2:0], 1'b0};
      end
    end
  end

  assign weight = (quo_r > rd_r.visits) ? 32'd0 : rd_r.visits - quo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      live_r   <= '0;
      occ_r    <= '0;
      hit_r    <= '0;
      miss_r   <= '0;
      found_r  <= 1'b0;
      best_v_r <= 1'b0;
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= cmd.emit;
      if (cmd.latch) begin
        found_r  <= 1'b0;
        best_v_r <= 1'b0;
        status_r <= ST_DONE;
        rval_r   <= '0;
        ev_r     <= 1'b0;
        evkey_r  <= '0;
      end
      if (cmd.find_chk) found_r <= match;
      if (cmd.best_upd && (!best_v_r || weight < best_w_r)) begin
        best_v_r   <= 1'b1;
        best_w_r   <= weight;
        best_key_r <= rd_r.key;
        best_idx_r <= idx_r;
      end
      if (cmd.act) begin
        if (op_r == OP_LOOKUP || op_r == OP_PEEK || op_r == OP_REMOVE) begin
          if (found_r) rval_r   <= rd_r.value;
          else         status_r <= ST_ABSENT;
        end
        if (op_r == OP_LOOKUP) begin
          if (found_r) hit_r  <= hit_r + 32'd1;
          else         miss_r <= miss_r + 32'd1;
        end
        if (op_r == OP_REMOVE && found_r) begin
          live_r[mem_wa] <= 1'b0;
          occ_r          <= occ_r - OCC_W'(1);
        end
      end
      if (cmd.evict) begin
        if (best_v_r) begin
          ev_r               <= 1'b1;
          evkey_r            <= best_key_r;
          live_r[best_idx_r] <= 1'b0;
          occ_r              <= occ_r - OCC_W'(1);
        end else begin
          status_r <= ST_EMPTY;
        end
      end
      if (cmd.insert) begin
        live_r[free_idx] <= 1'b1;
        occ_r            <= occ_r + OCC_W'(1);
      end
    end
  end

  always_comb begin
    sts.op         = op_r;
    sts.match      = match;
    sts.found      = found_r;
    sts.idx_last   = (idx_r == IDX_W'(DEPTH - 1));
    sts.live_cur   = live_r[idx_r];
    sts.div_done   = (dcnt_r == '0);
    sts.need_evict = (occ_r >= cap_eff);
  end

  assign out_strobe      = strobe_r;
  assign out_status      = status_r;
  assign out_read_value  = rval_r;
  assign out_evicted     = ev_r;
  assign out_evicted_key = evkey_r;
  assign out_occupancy   = occ_r;
  assign out_hit_total   = hit_r;
  assign out_miss_total  = miss_r;
endmodule
`default_nettype wire

// ===== rtl/decaying_lfu_cache_table.sv =====
// Lookup, peek, remove and write scan the slots in order (read, then compare) until the
// key matches or the last slot is checked, then act and emit the result; an evicting
// scan reads every slot and runs the bit-serial decay divider on each live slot. One
// item at a time: busy drops in the result strobe cycle; results cannot stall.
// Reset (synchronous, rst_n low) empties the table, clears counters, loads defaults.
`timescale 1ns / 1ps
`default_nettype none
module decaying_lfu_cache_table (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic [2:0]                  in_operation,
  input  wire logic [lfu_pkg::KEY_W-1:0]   in_key,
  input  wire logic [lfu_pkg::VAL_W-1:0]   in_write_value,
  input  wire logic [lfu_pkg::TIME_W-1:0]  in_now_minutes,
  output logic                             out_strobe,
  output logic [1:0]                       out_status,
  output logic [lfu_pkg::VAL_W-1:0]        out_read_value,
  output logic                             out_evicted,
  output logic [lfu_pkg::KEY_W-1:0]        out_evicted_key,
  output logic [lfu_pkg::OCC_W-1:0]        out_occupancy,
  output logic [31:0]                      out_hit_total,
  output logic [31:0]                      out_miss_total,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [3:0]                  paddr,
  input  wire logic [31:0]                 pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);
  import lfu_pkg::*;

  logic [OCC_W-1:0] cap_r;
  logic [31:0]      ivis_r;
  logic [DEC_W-1:0] dec_r;
  logic [OCC_W-1:0] cap_eff;
  logic [DEC_W-1:0] decay_eff;
  logic             wr_en;
  cmd_t             cmd;
  sts_t             sts;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r  <= OCC_W'(DEPTH);
      ivis_r <= 32'd255;
      dec_r  <= DEC_W'(10);
    end else if (wr_en) begin
      unique case (paddr)
        ADDR_CAP:   cap_r  <= pwdata[OCC_W-1:0];
        ADDR_IVIS:  ivis_r <= pwdata;
        ADDR_DECAY: dec_r  <= pwdata[DEC_W-1:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr)
      ADDR_CAP:   prdata = {{(32-OCC_W){1'b0}}, cap_r};
      ADDR_IVIS:  prdata = ivis_r;
      ADDR_DECAY: prdata = {{(32-DEC_W){1'b0}}, dec_r};
      default:    prdata = '0;
    endcase
  end

  // saturate capacity into 1..DEPTH, treat zero decay as one
  assign cap_eff   = (cap_r == '0) ? OCC_W'(1) :
                     (cap_r > OCC_W'(DEPTH)) ? OCC_W'(DEPTH) : cap_r;
  assign decay_eff = (dec_r == '0) ? DEC_W'(1) : dec_r;

  lfu_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .in_operation (in_operation),
    .sts          (sts),
    .cmd          (cmd),
    .busy         (busy)
  );

  lfu_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_operation    (in_operation),
    .in_key          (in_key),
    .in_write_value  (in_write_value),
    .in_now_minutes  (in_now_minutes),
    .cap_eff         (cap_eff),
    .init_visits     (ivis_r),
    .decay_eff       (decay_eff),
    .cmd             (cmd),
    .sts             (sts),
    .out_strobe      (out_strobe),
    .out_status      (out_status),
    .out_read_value  (out_read_value),
    .out_evicted     (out_evicted),
    .out_evicted_key (out_evicted_key),
    .out_occupancy   (out_occupancy),
    .out_hit_total   (out_hit_total),
    .out_miss_total  (out_miss_total)
  );
endmodule
`default_nettype wire

// ===== rtl/lfu_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module lfu_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       start,
  input wire logic       busy,
  input wire logic       out_strobe,
  input wire logic [1:0] out_status,
  input wire logic       out_evicted,
  input wire logic [6:0] out_occupancy
);
  import lfu_pkg::*;

  `LFU_ASSERT_NXT(a_accept_busy, clk, rst_n, start && !busy, busy)
  `LFU_ASSERT_IMP(a_strobe_idle, clk, rst_n, out_strobe, !busy)
  `LFU_ASSERT_IMP(a_occ_range, clk, rst_n, out_strobe, out_occupancy <= 7'(DEPTH))
  `LFU_ASSERT_IMP(a_empty_none, clk, rst_n, out_strobe && out_status == ST_EMPTY,
    out_occupancy == '0 && !out_evicted)
endmodule

bind decaying_lfu_cache_table lfu_checker u_lfu_checker (.*);
`default_nettype wire

// ===== sim/decaying_lfu_cache_table_tb.sv =====
`timescale 1ns / 1ps
module decaying_lfu_cache_table_tb;
  import lfu_pkg::*;

  localparam logic [2:0] OP_RSVD_A = 3'd5;
  localparam logic [2:0] OP_RSVD_B = 3'd6;
  localparam logic [2:0] OP_RSVD_C = 3'd7;
  localparam int unsigned CYCLE_LIMIT = 15000000;
  localparam int unsigned N_PHASES = 6;

  typedef struct packed {
    logic [1:0]       status;
    logic [VAL_W-1:0] read_value;
    logic             evicted;
    logic [KEY_W-1:0] evicted_key;
    logic [OCC_W-1:0] occupancy;
    logic [31:0]      hits;
    logic [31:0]      misses;
  } lfu_result_t;

  typedef struct packed {
    logic [2:0]        op;
    logic [KEY_W-1:0]  key;
    logic [VAL_W-1:0]  value;
    logic [TIME_W-1:0] now;
    logic              typed;
    logic [1:0]        exp_status;
    logic [VAL_W-1:0]  exp_read;
  } directed_row_t;

  typedef struct packed {
    logic [6:0]  cap;
    logic [31:0] ivis;
    logic [15:0] decay;
    logic [7:0]  pool;
    logic [15:0] items;
  } phase_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [2:0] in_operation = '0;
  logic [KEY_W-1:0] in_key = '0;
  logic [VAL_W-1:0] in_write_value = '0;
  logic [TIME_W-1:0] in_now_minutes = '0;
  logic out_strobe;
  logic [1:0] out_status;
  logic [VAL_W-1:0] out_read_value;
  logic out_evicted;
  logic [KEY_W-1:0] out_evicted_key;
  logic [OCC_W-1:0] out_occupancy;
  logic [31:0] out_hit_total;
  logic [31:0] out_miss_total;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  decaying_lfu_cache_table dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_operation(in_operation), .in_key(in_key), .in_write_value(in_write_value),
    .in_now_minutes(in_now_minutes), .out_strobe(out_strobe), .out_status(out_status),
    .out_read_value(out_read_value), .out_evicted(out_evicted),
    .out_evicted_key(out_evicted_key), .out_occupancy(out_occupancy),
    .out_hit_total(out_hit_total), .out_miss_total(out_miss_total),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // shadow table
  logic              tbl_live [DEPTH];
  logic [KEY_W-1:0]  tbl_key [DEPTH];
  logic [VAL_W-1:0]  tbl_value [DEPTH];
  logic [31:0]       tbl_visits [DEPTH];
  logic [TIME_W-1:0] tbl_last [DEPTH];
  logic [31:0] hit_count, miss_count;
  logic [6:0]  cfg_capacity;
  logic [31:0] cfg_initial_visits;
  logic [15:0] cfg_decay;

  lfu_result_t pending_results[$];
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  int unsigned items_sent = 0;
  int unsigned sender_idle_pct = 11;
  logic [KEY_W-1:0] key_pool[$];
  logic [TIME_W-1:0] clock_minutes = '0;

  initial begin
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic logic [31:0] entry_weight(int s, logic [TIME_W-1:0] now);
    logic [31:0] d, num;
    d = (cfg_decay == 0) ? 32'd1 : {16'd0, cfg_decay};
    num = (now - tbl_last[s]) / d;
    return (num > tbl_visits[s]) ? 32'd0 : tbl_visits[s] - num;
  endfunction

  function automatic int lightest_slot(logic [TIME_W-1:0] now);
    int best;
    logic [31:0] wmin, w;
    best = -1;
    wmin = 0;
    for (int i = 0; i < DEPTH; i++) begin
      if (tbl_live[i]) begin
        w = entry_weight(i, now);
        if (best < 0 || w < wmin) begin
          wmin = w;
          best = i;
        end
      end
    end
    return best;
  endfunction

  function automatic int live_entries();
    int n;
    n = 0;
    for (int i = 0; i < DEPTH; i++) if (tbl_live[i]) n++;
    return n;
  endfunction

  function automatic int slot_of_key(logic [KEY_W-1:0] k);
    for (int i = 0; i < DEPTH; i++) if (tbl_live[i] && tbl_key[i] == k) return i;
    return -1;
  endfunction

  task automatic apply_cache_op(input logic [2:0] op, input logic [KEY_W-1:0] k,
                                input logic [VAL_W-1:0] v, input logic [TIME_W-1:0] now,
                                output lfu_result_t r);
    int s, victim, cap;
    r = '0;
    r.status = ST_DONE;
    cap = (cfg_capacity == 0) ? 1 : ((cfg_capacity > DEPTH) ? DEPTH : cfg_capacity);
    case (op)
      OP_LOOKUP, OP_PEEK: begin
        s = slot_of_key(k);
        if (s < 0) begin
          r.status = ST_ABSENT;
          if (op == OP_LOOKUP) miss_count++;
        end else begin
          r.read_value = tbl_value[s];
          if (op == OP_LOOKUP) begin
            hit_count++;
            if (tbl_visits[s] != 32'hFFFF_FFFF) tbl_visits[s]++;
            tbl_last[s] = now;
          end
        end
      end
      OP_WRITE: begin
        s = slot_of_key(k);
        if (s >= 0) begin
          tbl_value[s] = v;
        end else begin
          if (live_entries() >= cap) begin
            victim = lightest_slot(now);
            if (victim >= 0) begin
              r.evicted = 1'b1;
              r.evicted_key = tbl_key[victim];
              tbl_live[victim] = 1'b0;
            end
          end
          // take the lowest free slot
          for (int i = 0; i < DEPTH; i++) begin
            if (!tbl_live[i]) begin
              tbl_live[i] = 1'b1;
              tbl_key[i] = k;
              tbl_value[i] = v;
              tbl_visits[i] = cfg_initial_visits;
              tbl_last[i] = now;
              break;
            end
          end
        end
      end
      OP_REMOVE: begin
        s = slot_of_key(k);
        if (s < 0) begin
          r.status = ST_ABSENT;
        end else begin
          r.read_value = tbl_value[s];
          tbl_live[s] = 1'b0;
        end
      end
      OP_EVICT: begin
        victim = lightest_slot(now);
        if (victim < 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.evicted = 1'b1;
          r.evicted_key = tbl_key[victim];
          tbl_live[victim] = 1'b0;
        end
      end
      default: ;
    endcase
    r.occupancy = OCC_W'(live_entries());
    r.hits = hit_count;
    r.misses = miss_count;
  endtask

  task automatic issue_item(input logic [2:0] op, input logic [KEY_W-1:0] k,
                            input logic [VAL_W-1:0] v, input logic [TIME_W-1:0] now,
                            output lfu_result_t r);
    while ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_operation <= op;
    in_key <= k;
    in_write_value <= v;
    in_now_minutes <= now;
    do @(posedge clk); while (busy !== 1'b0);
    apply_cache_op(op, k, v, now, r);
    pending_results.push_back(r);
    items_sent++;
    if (items_sent > 383) sender_idle_pct = (items_sent > 766) ? 0 : 64;
  endtask

  // hold off until every result has come back
  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_register(input logic [3:0] addr, input logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (addr)
      ADDR_CAP:   cfg_capacity = data[6:0];
      ADDR_IVIS:  cfg_initial_visits = data;
      ADDR_DECAY: cfg_decay = data[15:0];
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    lfu_result_t e;
    if (rst_n && out_strobe) begin
      if (pending_results.size() == 0) begin
        $error("result with no item outstanding");
        error_count++;
      end else begin
        e = pending_results.pop_front();
        if (out_status !== e.status) begin
          $error("status expected %0h got %0h", e.status, out_status);
          error_count++;
        end
        if (out_read_value !== e.read_value) begin
          $error("read_value expected %0h got %0h", e.read_value, out_read_value);
          error_count++;
        end
        if (out_evicted !== e.evicted) begin
          $error("evicted expected %0h got %0h", e.evicted, out_evicted);
          error_count++;
        end
        if (out_evicted_key !== e.evicted_key) begin
          $error("evicted_key expected %0h got %0h", e.evicted_key, out_evicted_key);
          error_count++;
        end
        if (out_occupancy !== e.occupancy) begin
          $error("occupancy expected %0d got %0d", e.occupancy, out_occupancy);
          error_count++;
        end
        if (out_hit_total !== e.hits) begin
          $error("hit_total expected %0d got %0d", e.hits, out_hit_total);
          error_count++;
        end
        if (out_miss_total !== e.misses) begin
          $error("miss_total expected %0d got %0d", e.misses, out_miss_total);
          error_count++;
        end
      end
    end
  end

  directed_row_t directed_rows[] = '{
    '{OP_LOOKUP, 32'h0, 32'h0, 32'h0, 1'b1, ST_ABSENT, 32'h0},
    '{OP_EVICT, 32'h0, 32'h0, 32'h0, 1'b1, ST_EMPTY, 32'h0},
    '{OP_REMOVE, 32'hFFFF_FFFF, 32'h0, 32'h1, 1'b1, ST_ABSENT, 32'h0},
    '{OP_PEEK, 32'hFFFF_FFFF, 32'h0, 32'h2, 1'b1, ST_ABSENT, 32'h0},
    '{OP_WRITE, 32'h0, 32'hFFFF_FFFF, 32'h0, 1'b1, ST_DONE, 32'h0},
    '{OP_WRITE, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 1'b1, ST_DONE, 32'h0},
    '{OP_LOOKUP, 32'h0, 32'h0, 32'h5, 1'b1, ST_DONE, 32'hFFFF_FFFF},
    '{OP_PEEK, 32'hFFFF_FFFF, 32'h0, 32'h6, 1'b1, ST_DONE, 32'h0},
    '{OP_WRITE, 32'h0, 32'h1234_5678, 32'h7, 1'b1, ST_DONE, 32'h0},
    '{OP_PEEK, 32'h0, 32'h0, 32'h8, 1'b1, ST_DONE, 32'h1234_5678},
    '{OP_RSVD_A, 32'h0, 32'hFFFF_FFFF, 32'h9, 1'b1, ST_DONE, 32'h0},
    '{OP_RSVD_B, 32'hFFFF_FFFF, 32'h0, 32'hA, 1'b1, ST_DONE, 32'h0},
    '{OP_RSVD_C, 32'h0, 32'h0, 32'hB, 1'b1, ST_DONE, 32'h0},
    '{OP_WRITE, 32'hA5A5_5A5A, 32'h5A5A_A5A5, 32'h8000_0000, 1'b0, ST_DONE, 32'h0},
    '{OP_EVICT, 32'h0, 32'h0, 32'h8000_0010, 1'b0, ST_DONE, 32'h0},
    '{OP_REMOVE, 32'h0, 32'h0, 32'h8000_0011, 1'b1, ST_ABSENT, 32'h0},
    '{OP_EVICT, 32'h0, 32'h0, 32'h8000_0012, 1'b0, ST_DONE, 32'h0},
    '{OP_EVICT, 32'h0, 32'h0, 32'h8000_0013, 1'b0, ST_DONE, 32'h0},
    '{OP_EVICT, 32'h0, 32'h0, 32'h8000_0014, 1'b1, ST_EMPTY, 32'h0},
    '{OP_LOOKUP, 32'h7, 32'h0, 32'h8000_0015, 1'b1, ST_ABSENT, 32'h0}
  };

  // capacity 0 and 127 saturate; lowering capacity while full leaves entries in place
  phase_t cache_phases[N_PHASES] = '{
    '{7'd64, 32'd255, 16'd10, 8'd80, 16'd140},
    '{7'd1, 32'hFFFF_FFFF, 16'd1, 8'd4, 16'd200},
    '{7'd0, 32'd0, 16'd0, 8'd6, 16'd200},
    '{7'd127, 32'd7, 16'hFFFF, 8'd80, 16'd150},
    '{7'd4, 32'd3, 16'd1, 8'd10, 16'd250},
    '{7'd16, 32'd100, 16'd5, 8'd24, 16'd210}
  };

  initial begin
    lfu_result_t r;
    logic [2:0] op;
    logic [KEY_W-1:0] k;
    int unsigned pick;
    for (int i = 0; i < DEPTH; i++) tbl_live[i] = 1'b0;
    hit_count = 0;
    miss_count = 0;
    cfg_capacity = 7'd64;
    cfg_initial_visits = 32'd255;
    cfg_decay = 16'd10;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      issue_item(directed_rows[i].op, directed_rows[i].key, directed_rows[i].value,
                 directed_rows[i].now, r);
      if (directed_rows[i].typed &&
          (r.status != directed_rows[i].exp_status || r.read_value != directed_rows[i].exp_read))
      begin
        $error("row %0d status/read_value expected %0h/%0h got %0h/%0h", i,
               directed_rows[i].exp_status, directed_rows[i].exp_read, r.status, r.read_value);
        error_count++;
      end
    end
    drain_results();
    // saturate visits at the top
    write_register(ADDR_IVIS, 32'hFFFF_FFFF);
    issue_item(OP_WRITE, 32'h55, 32'h66, 32'h0, r);
    issue_item(OP_LOOKUP, 32'h55, 32'h0, 32'h0, r);
    issue_item(OP_REMOVE, 32'h55, 32'h0, 32'h0, r);
    drain_results();

    foreach (cache_phases[p]) begin
      write_register(ADDR_CAP, {25'd0, cache_phases[p].cap});
      write_register(ADDR_IVIS, cache_phases[p].ivis);
      write_register(ADDR_DECAY, {16'd0, cache_phases[p].decay});
      key_pool.delete();
      key_pool.push_back(32'h0);
      key_pool.push_back(32'hFFFF_FFFF);
      while (key_pool.size() < cache_phases[p].pool) key_pool.push_back($urandom);
      for (int n = 0; n < cache_phases[p].items; n++) begin
        pick = $urandom_range(99);
        if (pick < 30) op = OP_LOOKUP;
        else if (pick < 42) op = OP_PEEK;
        else if (pick < 77) op = OP_WRITE;
        else if (pick < 88) op = OP_REMOVE;
        else if (pick < 95) op = OP_EVICT;
        else op = 3'($urandom_range(OP_RSVD_A, OP_RSVD_C));
        k = ($urandom_range(19) == 0) ? $urandom
                                      : key_pool[$urandom_range(key_pool.size() - 1)];
        // advance time slowly, jump now and then
        if ($urandom_range(19) == 0) clock_minutes = $urandom;
        else clock_minutes = clock_minutes + $urandom_range(0, 3);
        issue_item(op, k, $urandom, clock_minutes, r);
      end
      drain_results();
    end

    repeat (50) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d results never arrived", pending_results.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
